// ----- rtl/chen_pkg.sv -----
// ----------------------------------------------------------------------------
// chen_pkg
// Shared types, constants and helper functions of the Chen keystream block.
// ----------------------------------------------------------------------------
package chen_pkg;

  // register indexes of the write port
  localparam logic [2:0] REG_START_X = 3'd0;
  localparam logic [2:0] REG_START_Y = 3'd1;
  localparam logic [2:0] REG_START_Z = 3'd2;
  localparam logic [2:0] REG_CHEN_C  = 3'd3;
  localparam logic [2:0] REG_WARMUP  = 3'd4;
  localparam logic [2:0] REG_SCALE   = 3'd5;

  // operations of the shared float32 unit
  typedef enum logic [1:0] {
    FPU_ADD,
    FPU_SUB,
    FPU_MUL,
    FPU_CVT
  } fpu_op_e;

  // operand sources of the sequencer
  typedef enum logic [3:0] {
    SRC_X,
    SRC_Y,
    SRC_Z,
    SRC_C,
    SRC_A,
    SRC_B,
    SRC_T0,
    SRC_T1,
    SRC_T2,
    SRC_MAG,
    SRC_FL,
    SRC_SCALE
  } src_e;

  // result destinations of the sequencer
  typedef enum logic [2:0] {
    DST_T0,
    DST_T1,
    DST_T2,
    DST_NX,
    DST_NY,
    DST_NZ,
    DST_BYTE
  } dst_e;

  // one step of the sequencer program
  typedef struct packed {
    fpu_op_e op;
    src_e    src_a;
    src_e    src_b;
    dst_e    dst;
  } uop_t;

  // request into the float unit
  typedef struct packed {
    logic        start;
    fpu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  localparam logic [31:0] CHEN_A = 32'h420C_0000;  // 35.0
  localparam logic [31:0] CHEN_B = 32'h4040_0000;  // 3.0

  localparam logic [3:0] PC_ITER_LAST = 4'd10;
  localparam logic [3:0] PC_CVT       = 4'd11;
  localparam logic [3:0] PC_FRAC      = 4'd12;
  localparam logic [3:0] PC_SCALE     = 4'd13;

  // sequencer program: one chen iteration, then the byte extraction
  function automatic uop_t uop_at(input logic [3:0] pc);
    uop_t u;
    case (pc)
      4'd0:  u = '{FPU_SUB, SRC_Y,     SRC_X,     DST_T0};
      4'd1:  u = '{FPU_MUL, SRC_A,     SRC_T0,    DST_NX};
      4'd2:  u = '{FPU_SUB, SRC_C,     SRC_A,     DST_T0};
      4'd3:  u = '{FPU_MUL, SRC_T0,    SRC_X,     DST_T0};
      4'd4:  u = '{FPU_MUL, SRC_X,     SRC_Z,     DST_T1};
      4'd5:  u = '{FPU_SUB, SRC_T0,    SRC_T1,    DST_T0};
      4'd6:  u = '{FPU_MUL, SRC_C,     SRC_Y,     DST_T1};
      4'd7:  u = '{FPU_ADD, SRC_T0,    SRC_T1,    DST_NY};
      4'd8:  u = '{FPU_MUL, SRC_X,     SRC_Y,     DST_T0};
      4'd9:  u = '{FPU_MUL, SRC_B,     SRC_Z,     DST_T1};
      4'd10: u = '{FPU_SUB, SRC_T0,    SRC_T1,    DST_NZ};
      4'd12: u = '{FPU_SUB, SRC_MAG,   SRC_FL,    DST_T0};
      4'd13: u = '{FPU_MUL, SRC_T0,    SRC_T2,    DST_BYTE};
      default: u = '{FPU_CVT, SRC_SCALE, SRC_SCALE, DST_T2};
    endcase
    return u;
  endfunction

  // keep or normalize mantissa, replace binary exponent by its low four bits
  function automatic logic [31:0] fp_rescale(input logic [31:0] b);
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  s;
    logic [22:0] mn;
    logic [3:0]  lo;
    logic [31:0] r;
    e = b[30:23];
    m = b[22:0];
    s = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (m[i]) s = 5'(23 - i);
    end
    mn = 23'({1'b0, m} << s);
    if (e == 8'hFF || (e == 8'h00 && m == 23'd0)) begin
      r = b;
    end else if (e == 8'h00) begin
      lo = 4'(4'd3 - s[3:0]);
      r  = {b[31], 8'(8'd126 + {4'b0, lo}), mn};
    end else begin
      lo = 4'(e[3:0] + 4'd2);
      r  = {b[31], 8'(8'd126 + {4'b0, lo}), m};
    end
    return r;
  endfunction

  // integer part of a non-negative float, large values and specials pass
  function automatic logic [31:0] fp_floor(input logic [31:0] mag);
    logic [7:0]  e;
    logic [4:0]  n;
    logic [22:0] mask;
    logic [31:0] r;
    e    = mag[30:23];
    n    = 5'(8'd150 - e);
    mask = 23'h7F_FFFF << n;
    if (e < 8'd127) begin
      r = 32'd0;
    end else if (e >= 8'd150) begin
      r = mag;
    end else begin
      r = {mag[31:23], mag[22:0] & mask};
    end
    return r;
  endfunction

  // low byte of the truncated integer of a non-negative float
  function automatic logic [7:0] fp_trunc_byte(input logic [31:0] p);
    logic [7:0]  e;
    logic [23:0] mant;
    logic [7:0]  sh;
    logic [23:0] v;
    logic [7:0]  r;
    e    = p[30:23];
    mant = {1'b1, p[22:0]};
    sh   = 8'd0;
    v    = 24'd0;
    if (e == 8'hFF || e < 8'd127) begin
      r = 8'd0;
    end else if (e <= 8'd150) begin
      sh = 8'(8'd150 - e);
      v  = mant >> sh;
      r  = v[7:0];
    end else begin
      sh = 8'(e - 8'd150);
      r  = (sh >= 8'd8) ? 8'd0 : 8'(mant[7:0] << sh[2:0]);
    end
    return r;
  endfunction

endpackage

// ----- rtl/chen_fpu.sv -----
// ----------------------------------------------------------------------------
// chen_fpu
// Three-stage float32 add, subtract, multiply and integer convert unit,
// round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module chen_fpu
  import chen_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fpu_req_t    req_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  localparam logic [31:0] QNAN = 32'h7FC0_0000;

  // stage a registers
  logic               a_vld_q;
  logic               a_spec_q;
  logic [31:0]        a_res_q;
  logic               a_sign_q;
  logic signed [10:0] a_exp_q;
  logic [47:0]        a_man_q;

  // stage b registers
  logic               b_vld_q;
  logic               b_spec_q;
  logic               b_zero_q;
  logic [31:0]        b_res_q;
  logic               b_sign_q;
  logic signed [10:0] b_exp_q;
  logic [47:0]        b_man_q;

  // stage c registers
  logic        done_q;
  logic [31:0] res_q;

  // operand fields
  logic        sa, sb, sbe;
  logic [7:0]  ea, eb, ea_eff, eb_eff;
  logic [23:0] siga, sigb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  assign sa     = req_i.a[31];
  assign sb     = req_i.b[31];
  assign ea     = req_i.a[30:23];
  assign eb     = req_i.b[30:23];
  assign ea_eff = (ea == 8'h00) ? 8'd1 : ea;
  assign eb_eff = (eb == 8'h00) ? 8'd1 : eb;
  assign siga   = {(ea != 8'h00), req_i.a[22:0]};
  assign sigb   = {(eb != 8'h00), req_i.b[22:0]};
  assign nan_a  = (ea == 8'hFF) && (req_i.a[22:0] != 23'd0);
  assign nan_b  = (eb == 8'hFF) && (req_i.b[22:0] != 23'd0);
  assign inf_a  = (ea == 8'hFF) && (req_i.a[22:0] == 23'd0);
  assign inf_b  = (eb == 8'hFF) && (req_i.b[22:0] == 23'd0);
  assign zero_a = (ea == 8'h00) && (req_i.a[22:0] == 23'd0);
  assign zero_b = (eb == 8'h00) && (req_i.b[22:0] == 23'd0);
  assign sbe    = sb ^ (req_i.op == FPU_SUB);

  // alignment for add and subtract
  logic        a_big;
  logic [7:0]  e_big, e_small, d;
  logic [5:0]  dsat;
  logic [23:0] sig_big, sig_small;
  logic        s_big, s_small;
  logic [95:0] al_wide;
  logic [47:0] sm, big_m, prod;

  assign a_big     = {ea_eff, siga} >= {eb_eff, sigb};
  assign e_big     = a_big ? ea_eff : eb_eff;
  assign e_small   = a_big ? eb_eff : ea_eff;
  assign sig_big   = a_big ? siga : sigb;
  assign sig_small = a_big ? sigb : siga;
  assign s_big     = a_big ? sa : sbe;
  assign s_small   = a_big ? sbe : sa;
  assign d         = e_big - e_small;
  assign dsat      = (d > 8'd63) ? 6'd63 : d[5:0];
  assign al_wide   = {1'b0, sig_small, 23'd0, 48'd0} >> dsat;
  assign sm        = al_wide[95:48] | {47'd0, |al_wide[47:0]};
  assign big_m     = {1'b0, sig_big, 23'd0};
  assign prod      = siga * sigb;

  // stage a: specials, multiply, convert or align and add
  logic               spec_a;
  logic [31:0]        sres_a;
  logic               sign_a;
  logic signed [10:0] exp_a;
  logic [47:0]        man_a;

  always_comb begin
    spec_a = 1'b0;
    sres_a = 32'd0;
    sign_a = 1'b0;
    exp_a  = 11'sd0;
    man_a  = 48'd0;
    case (req_i.op)
      FPU_MUL: begin
        sign_a = sa ^ sb;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a)) begin
          spec_a = 1'b1;
          sres_a = QNAN;
        end else if (inf_a || inf_b) begin
          spec_a = 1'b1;
          sres_a = {sa ^ sb, 8'hFF, 23'd0};
        end else if (zero_a || zero_b) begin
          spec_a = 1'b1;
          sres_a = {sa ^ sb, 31'd0};
        end
        exp_a = $signed({3'b0, ea_eff}) + $signed({3'b0, eb_eff}) - 11'sd127;
        man_a = prod;
      end
      FPU_CVT: begin
        exp_a = 11'sd150;
        man_a = {req_i.a[24:0], 23'd0};
      end
      default: begin
        sign_a = s_big;
        if (nan_a || nan_b || (inf_a && inf_b && (sa != sbe))) begin
          spec_a = 1'b1;
          sres_a = QNAN;
        end else if (inf_a) begin
          spec_a = 1'b1;
          sres_a = {sa, 8'hFF, 23'd0};
        end else if (inf_b) begin
          spec_a = 1'b1;
          sres_a = {sbe, 8'hFF, 23'd0};
        end else if (zero_a && zero_b) begin
          spec_a = 1'b1;
          sres_a = {sa & sbe, 31'd0};
        end
        exp_a = $signed({3'b0, e_big});
        man_a = (s_big == s_small) ? big_m + sm : big_m - sm;
      end
    endcase
  end

  // stage b: leading zero count and left normalize
  logic [5:0]         lz;
  logic signed [10:0] exp_b;

  always_comb begin
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (a_man_q[i]) lz = 6'(47 - i);
    end
  end

  assign exp_b = a_exp_q - $signed({5'b0, lz}) + 11'sd1;

  // stage c: subnormal shift, rounding and packing
  logic signed [10:0] rr, ef, ef2;
  logic [5:0]         rs;
  logic [95:0]        rn_wide;
  logic [47:0]        mm;
  logic [23:0]        mant24, mant;
  logic               guard, stk, inc;
  logic [24:0]        m25;
  logic [31:0]        res_c;

  assign rr      = 11'sd2 - b_exp_q;
  assign rs      = (b_exp_q >= 11'sd1) ? 6'd1 : ((rr > 11'sd63) ? 6'd63 : rr[5:0]);
  assign ef      = (b_exp_q >= 11'sd1) ? b_exp_q : 11'sd1;
  assign rn_wide = {b_man_q, 48'd0} >> rs;
  assign mm      = rn_wide[95:48];
  assign mant24  = mm[46:23];
  assign guard   = mm[22];
  assign stk     = (|mm[21:0]) | (|rn_wide[47:0]);
  assign inc     = guard & (stk | mant24[0]);
  assign m25     = {1'b0, mant24} + {24'd0, inc};
  assign mant    = m25[24] ? m25[24:1] : m25[23:0];
  assign ef2     = m25[24] ? ef + 11'sd1 : ef;

  always_comb begin
    if (b_spec_q) begin
      res_c = b_res_q;
    end else if (b_zero_q) begin
      res_c = 32'd0;
    end else if (ef2 >= 11'sd255) begin
      res_c = {b_sign_q, 8'hFF, 23'd0};
    end else begin
      res_c = {b_sign_q, (mant[23] ? ef2[7:0] : 8'd0), mant[22:0]};
    end
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      a_spec_q <= 1'b0;
      a_res_q  <= 32'd0;
      a_sign_q <= 1'b0;
      a_exp_q  <= 11'sd0;
      a_man_q  <= 48'd0;
      b_vld_q  <= 1'b0;
      b_spec_q <= 1'b0;
      b_zero_q <= 1'b0;
      b_res_q  <= 32'd0;
      b_sign_q <= 1'b0;
      b_exp_q  <= 11'sd0;
      b_man_q  <= 48'd0;
      done_q   <= 1'b0;
      res_q    <= 32'd0;
    end else begin
      a_vld_q  <= req_i.start;
      a_spec_q <= spec_a;
      a_res_q  <= sres_a;
      a_sign_q <= sign_a;
      a_exp_q  <= exp_a;
      a_man_q  <= man_a;
      b_vld_q  <= a_vld_q;
      b_spec_q <= a_spec_q;
      b_zero_q <= (a_man_q == 48'd0);
      b_res_q  <= a_res_q;
      b_sign_q <= a_sign_q;
      b_exp_q  <= exp_b;
      b_man_q  <= a_man_q << lz;
      done_q   <= b_vld_q;
      res_q    <= res_c;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- rtl/chen_chaotic_keystream.sv -----
// ----------------------------------------------------------------------------
// chen_chaotic_keystream
// Float32 Chen chaotic system stepped per item, three keystream bytes out.
// ----------------------------------------------------------------------------
// Usage: each input item on the s_axis channel carries one flag, restart, in
// tdata bit 0. A restart item reloads the start point, runs warmup_steps
// iterations and one more; any other item runs one iteration. Each item
// yields one output item with three key bytes (x, y, z) on m_axis.
// One iteration is a rescale plus eleven operations of the shared
// three-stage float unit; byte extraction takes seven more operations, and
// a restart item adds one iteration per warm-up step.
// s_axis_tready is high only while the sequencer is idle.
// Reset clears the point to zero and loads the register defaults; there is
// no clearing pass. A stalled receiver holds the result in the output
// register; the next item is still accepted and its finished result waits
// in the sequencer, with s_axis_tready low, until the output register frees.
// Registers are written through cfg_we_i, cfg_addr_i, cfg_wdata_i; the user
// must write them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module chen_chaotic_keystream
  import chen_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [0] restart, [7:1] zero fill
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] key_byte_x, [15:8] key_byte_y,
                                      // [23:16] key_byte_z
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RESC,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } state_e;

  // configuration registers
  logic [31:0] start_x_q, start_y_q, start_z_q, chen_c_q;
  logic [9:0]  warmup_q;
  logic [24:0] scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= 32'd0;
      start_y_q <= 32'd0;
      start_z_q <= 32'd0;
      chen_c_q  <= 32'h41E0_0000;
      warmup_q  <= 10'd189;
      scale_q   <= 25'd1000000;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_START_X: start_x_q <= cfg_wdata_i;
        REG_START_Y: start_y_q <= cfg_wdata_i;
        REG_START_Z: start_z_q <= cfg_wdata_i;
        REG_CHEN_C:  chen_c_q  <= cfg_wdata_i;
        REG_WARMUP:  warmup_q  <= cfg_wdata_i[9:0];
        REG_SCALE:   scale_q   <= cfg_wdata_i[24:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  state_e      state_q;
  logic [3:0]  pc_q;
  logic [1:0]  k_q;
  logic [9:0]  rem_q;
  logic [31:0] chaos_x_q, chaos_y_q, chaos_z_q;
  logic [31:0] rx_q, ry_q, rz_q;
  logic [31:0] t0_q, t1_q, t2_q;
  logic [7:0]  byte_q [3];
  logic [23:0] out_q;
  logic        out_vld_q;

  // operand selection
  uop_t        uop;
  logic [31:0] mag, fl;
  fpu_req_t    fpu_req;
  logic        fpu_done;
  logic [31:0] fpu_res;

  assign uop = uop_at(pc_q);

  always_comb begin
    case (k_q)
      2'd0:    mag = {1'b0, chaos_x_q[30:0]};
      2'd1:    mag = {1'b0, chaos_y_q[30:0]};
      default: mag = {1'b0, chaos_z_q[30:0]};
    endcase
  end

  assign fl = fp_floor(mag);

  function automatic logic [31:0] pick(input src_e s, input logic [31:0] x,
                                       input logic [31:0] y, input logic [31:0] z,
                                       input logic [31:0] c, input logic [31:0] t0,
                                       input logic [31:0] t1, input logic [31:0] t2,
                                       input logic [31:0] mg, input logic [31:0] fv,
                                       input logic [24:0] sc);
    logic [31:0] r;
    case (s)
      SRC_X:   r = x;
      SRC_Y:   r = y;
      SRC_Z:   r = z;
      SRC_C:   r = c;
      SRC_A:   r = CHEN_A;
      SRC_B:   r = CHEN_B;
      SRC_T0:  r = t0;
      SRC_T1:  r = t1;
      SRC_T2:  r = t2;
      SRC_MAG: r = mg;
      SRC_FL:  r = fv;
      default: r = {7'd0, sc};
    endcase
    return r;
  endfunction

  assign fpu_req.start = (state_q == ST_ISSUE);
  assign fpu_req.op    = uop.op;
  assign fpu_req.a     = pick(uop.src_a, rx_q, ry_q, rz_q, chen_c_q, t0_q, t1_q, t2_q,
                              mag, fl, scale_q);
  assign fpu_req.b     = pick(uop.src_b, rx_q, ry_q, rz_q, chen_c_q, t0_q, t1_q, t2_q,
                              mag, fl, scale_q);

  chen_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .done_o (fpu_done),
    .res_o  (fpu_res)
  );

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pc_q      <= 4'd0;
      k_q       <= 2'd0;
      rem_q     <= 10'd0;
      chaos_x_q <= 32'd0;
      chaos_y_q <= 32'd0;
      chaos_z_q <= 32'd0;
      rx_q      <= 32'd0;
      ry_q      <= 32'd0;
      rz_q      <= 32'd0;
      t0_q      <= 32'd0;
      t1_q      <= 32'd0;
      t2_q      <= 32'd0;
      byte_q    <= '{default: 8'd0};
      out_q     <= 24'd0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_vld_q && m_axis_tready && state_q != ST_DONE) out_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            if (s_axis_tdata[0]) begin
              chaos_x_q <= start_x_q;
              chaos_y_q <= start_y_q;
              chaos_z_q <= start_z_q;
              rem_q     <= warmup_q;
            end else begin
              rem_q <= 10'd0;
            end
            state_q <= ST_RESC;
          end
        end
        ST_RESC: begin
          rx_q    <= fp_rescale(chaos_x_q);
          ry_q    <= fp_rescale(chaos_y_q);
          rz_q    <= fp_rescale(chaos_z_q);
          pc_q    <= 4'd0;
          state_q <= ST_ISSUE;
        end
        ST_ISSUE: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (fpu_done) begin
            // write back the finished operation
            case (uop.dst)
              DST_T0:   t0_q <= fpu_res;
              DST_T1:   t1_q <= fpu_res;
              DST_T2:   t2_q <= fpu_res;
              DST_NX:   chaos_x_q <= fpu_res;
              DST_NY:   chaos_y_q <= fpu_res;
              DST_NZ:   chaos_z_q <= fpu_res;
              default:  byte_q[k_q] <= fp_trunc_byte(fpu_res);
            endcase
            // step the program
            case (pc_q)
              PC_ITER_LAST: begin
                if (rem_q != 10'd0) begin
                  rem_q   <= rem_q - 10'd1;
                  state_q <= ST_RESC;
                end else begin
                  pc_q    <= PC_CVT;
                  state_q <= ST_ISSUE;
                end
              end
              PC_CVT: begin
                pc_q    <= PC_FRAC;
                k_q     <= 2'd0;
                state_q <= ST_ISSUE;
              end
              PC_SCALE: begin
                if (k_q == 2'd2) begin
                  state_q <= ST_DONE;
                end else begin
                  k_q     <= k_q + 2'd1;
                  pc_q    <= PC_FRAC;
                  state_q <= ST_ISSUE;
                end
              end
              default: begin
                pc_q    <= pc_q + 4'd1;
                state_q <= ST_ISSUE;
              end
            endcase
          end
        end
        default: begin
          if (!out_vld_q || m_axis_tready) begin
            out_q     <= {byte_q[2], byte_q[1], byte_q[0]};
            out_vld_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_done_in_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fpu_done |-> state_q == ST_WAIT) else $error("fpu result outside wait state");
  a_k_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q != 2'd3) else $error("coordinate index out of range");
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready after accepting an item");
  a_wait_after_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ISSUE |=> ##2 (state_q == ST_WAIT && fpu_done))
    else $error("fpu latency mismatch");
`endif

endmodule

// ----- tb/chen_chaotic_keystream_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chen_chaotic_keystream_tb
// Self-checking bench for the Chen keystream block. A float32 model of the
// chaotic point predicts three key bytes per accepted item; the stream
// handshakes are idled and stalled at random while register settings change
// between phases.
// ----------------------------------------------------------------------------
module chen_chaotic_keystream_tb;
  import chen_pkg::*;

  localparam int HALF_PERIOD = 6;

  // register indexes outside the list
  localparam logic [2:0] REG_SPARE_6  = 3'd6;
  localparam logic [2:0] REG_SPARE_7  = 3'd7;

  localparam logic [31:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [31:0] FP_28    = 32'h41E0_0000;
  localparam logic [31:0] FP_INF   = 32'h7F80_0000;
  localparam logic [31:0] FP_NAN   = 32'h7FC0_0001;
  localparam logic [31:0] FP_NZERO = 32'h8000_0000;

  typedef struct packed {
    logic [7:0] kz;
    logic [7:0] ky;
    logic [7:0] kx;
  } key_set_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [0] restart, [7:1] zero fill
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [7:0] key x, [15:8] key y, [23:16] key z
  logic        cfg_we_i;
  logic [2:0]  cfg_addr_i;
  logic [31:0] cfg_wdata_i;

  chen_chaotic_keystream i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // predictor copy of registers and point
  logic [31:0] start_x_q, start_y_q, start_z_q, chen_c_q;
  logic [9:0]  warmup_q;
  logic [24:0] scale_q;
  logic [31:0] pt_x = 32'd0;
  logic [31:0] pt_y = 32'd0;
  logic [31:0] pt_z = 32'd0;

  bit       restart_pending[$];
  key_set_t keys_expected[$];
  int       n_fail = 0;
  int       n_mismatch = 0;

  // clock
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // float32 pattern widened to a double
  function automatic real fp32_to_real(input logic [31:0] b);
    logic [63:0] d;
    logic [7:0]  e;
    logic [22:0] m;
    int          k;
    e = b[30:23];
    m = b[22:0];
    k = 0;
    if (e == 8'hFF) begin
      d = {b[31], 11'h7FF, m, 29'd0};
    end else if (e == 8'h00 && m == 23'd0) begin
      d = {b[31], 63'd0};
    end else if (e == 8'h00) begin
      while (!m[22]) begin
        m = m << 1;
        k++;
      end
      m = m << 1;
      d = {b[31], 11'(1023 - 127 - k), m, 29'd0};
    end else begin
      d = {b[31], 11'(int'(e) - 127 + 1023), m, 29'd0};
    end
    return $bitstoreal(d);
  endfunction

  // round a double to float32, nearest even
  function automatic logic [31:0] real_to_fp32(input real r);
    logic [63:0] d;
    logic [63:0] sig, kept, rem, half;
    logic [31:0] base, bits;
    int          e, sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return {d[63], 8'hFF, (d[51:0] != 0) ? 23'h40_0000 : 23'd0};
    if (d[62:52] == 11'h000) return {d[63], 31'd0};
    e   = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    if (e > 127) return {d[63], 8'hFF, 23'd0};
    if (e >= -126) begin
      sh   = 29;
      base = 32'(e + 126) << 23;
    end else begin
      sh   = 29 + (-126 - e);
      base = 32'd0;
    end
    if (sh > 60) return {d[63], 31'd0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    bits = base + kept[31:0];
    if (bits >= FP_INF) bits = FP_INF;
    return {d[63], bits[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul32(input logic [31:0] p, input logic [31:0] q);
    return real_to_fp32(fp32_to_real(p) * fp32_to_real(q));
  endfunction

  function automatic logic [31:0] fp_sub32(input logic [31:0] p, input logic [31:0] q);
    return real_to_fp32(fp32_to_real(p) - fp32_to_real(q));
  endfunction

  function automatic logic [31:0] fp_add32(input logic [31:0] p, input logic [31:0] q);
    return real_to_fp32(fp32_to_real(p) + fp32_to_real(q));
  endfunction

  // fold the binary exponent into its low four bits
  function automatic logic [31:0] fold_exponent(input logic [31:0] b);
    logic [7:0]  e;
    logic [23:0] m;
    int          s, ex;
    e = b[30:23];
    m = {1'b0, b[22:0]};
    s = 0;
    if (e == 8'hFF || (e == 8'h00 && m == 24'd0)) return b;
    if (e == 8'h00) begin
      while (!m[23]) begin
        m = m << 1;
        s++;
      end
      ex = -125 - s;
    end else begin
      ex = int'(e) - 126;
    end
    return {b[31], 8'(126 + (ex & 15)), m[22:0]};
  endfunction

  // one chen iteration on the predicted point
  task automatic advance_point();
    logic [31:0] x, y, z, nx, ny, nz;
    x  = fold_exponent(pt_x);
    y  = fold_exponent(pt_y);
    z  = fold_exponent(pt_z);
    nx = fp_mul32(CHEN_A, fp_sub32(y, x));
    ny = fp_add32(fp_sub32(fp_mul32(fp_sub32(chen_c_q, CHEN_A), x), fp_mul32(x, z)),
                  fp_mul32(chen_c_q, y));
    nz = fp_sub32(fp_mul32(x, y), fp_mul32(CHEN_B, z));
    pt_x = nx;
    pt_y = ny;
    pt_z = nz;
  endtask

  // fractional part of the magnitude times scale, low byte
  function automatic logic [7:0] key_byte_of(input logic [31:0] bits);
    logic [31:0] mag, frac, sc, prod;
    real         a;
    mag = {1'b0, bits[30:0]};
    if (mag[30:23] == 8'hFF || mag >= 32'h4B00_0000) return 8'd0;
    a    = fp32_to_real(mag);
    frac = real_to_fp32(a - real'($rtoi(a)));
    sc   = real_to_fp32(real'(scale_q));
    prod = fp_mul32(frac, sc);
    return 8'($rtoi(fp32_to_real(prod)));
  endfunction

  task automatic predict_keys(input bit restart);
    key_set_t k;
    if (restart) begin
      pt_x = start_x_q;
      pt_y = start_y_q;
      pt_z = start_z_q;
      for (int i = 0; i < int'(warmup_q); i++) advance_point();
    end
    advance_point();
    k.kx = key_byte_of(pt_x);
    k.ky = key_byte_of(pt_y);
    k.kz = key_byte_of(pt_z);
    keys_expected.push_back(k);
  endtask

  // item driver, bursts with random gaps
  int burst_left, gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'd0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left > 0) begin
        gap_left      <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (restart_pending.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, restart_pending.pop_front()};
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // accepted items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) predict_keys(s_axis_tdata[0]);
  end

  // receiver stall pattern, the mode is chosen anew at random
  int stall_mode, stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
      stall_cnt     <= 0;
    end else begin
      if (stall_cnt == 0) begin
        stall_cnt  <= $urandom_range(100, 600);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        stall_cnt <= stall_cnt - 1;
      end
      m_axis_tready <= (stall_mode == 0) ? 1'b1 : ($urandom_range(0, 3) >= stall_mode);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    key_set_t want;
    key_set_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (keys_expected.size() == 0) begin
        n_fail++;
        if (n_mismatch < 10) $display("unexpected item: keys 0x%06h", got);
        n_mismatch++;
      end else begin
        want = keys_expected.pop_front();
        if (got.kx != want.kx || got.ky != want.ky || got.kz != want.kz) begin
          n_fail++;
          if (n_mismatch < 10) begin
            $display("key mismatch: x exp %02h got %02h, y exp %02h got %02h, z exp %02h got %02h",
                     want.kx, got.kx, want.ky, got.ky, want.kz, got.kz);
          end
          n_mismatch++;
        end
      end
    end
  end

  // register write, predictor copy follows
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_START_X: start_x_q = val;
      REG_START_Y: start_y_q = val;
      REG_START_Z: start_z_q = val;
      REG_CHEN_C:  chen_c_q  = val;
      REG_WARMUP:  warmup_q  = val[9:0];
      REG_SCALE:   scale_q   = val[24:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] sz, input logic [31:0] c,
                           input logic [31:0] warm, input logic [31:0] scale);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    write_reg(REG_CHEN_C, c);
    write_reg(REG_WARMUP, warm);
    write_reg(REG_SCALE, scale);
  endtask

  // wait until the block has drained
  task automatic drain();
    while (restart_pending.size() > 0 || s_axis_tvalid || keys_expected.size() > 0)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  // a float in the chaotic working range, mostly
  function automatic logic [31:0] rand_point();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return {1'($urandom), 8'($urandom_range(118, 132)), 23'($urandom)};
  endfunction

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'h100_0000;
      3: return 32'd1000000;
      default: return {7'd0, 25'($urandom)};
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    logic [31:0] c;
    int          warm;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = REG_START_X;
    cfg_wdata_i = 32'd0;
    start_x_q = 32'd0;
    start_y_q = 32'd0;
    start_z_q = 32'd0;
    chen_c_q  = FP_28;
    warmup_q  = 10'd189;
    scale_q   = 25'd1000000;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // defaults after reset: zero point, then a default warm-up
    restart_pending = '{1'b0, 1'b0, 1'b1, 1'b0};
    drain();

    // infinity, nan and subnormal start, scale beyond 2^24, no warm-up
    write_all(FP_INF, FP_NAN, 32'h0000_0003, FP_28, 32'd0, 32'h1FF_FFFF);
    restart_pending = '{1'b1, 1'b0, 1'b0, 1'b1};
    drain();

    // negative zero and subnormal, longest warm-up, zero scale
    write_all(32'h807F_FFFF, FP_NZERO, FP_ONE, 32'hC1E0_0000, 32'd1023, 32'd0);
    restart_pending = '{1'b1, 1'b0};
    drain();

    // spare indexes are ignored
    write_all(32'h3F00_0000, 32'h4120_0000, 32'hC0A0_0000, FP_28, 32'd1, 32'h100_0000);
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h0000_0000);
    restart_pending = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
    drain();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: c = $urandom;
        1: c = {1'($urandom), 8'($urandom_range(125, 134)), 23'($urandom)};
        default: c = FP_28;
      endcase
      warm = $urandom_range(0, 40);
      write_all(rand_point(), rand_point(), rand_point(), c, warm, rand_scale());
      restart_pending.push_back(1'b1);
      for (int i = 0; i < 215; i++) restart_pending.push_back($urandom_range(0, 7) == 0);
      drain();
    end

    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
